@@ hw/rtl/lmr_pkg.sv @@
// ----------------------------------------------------------------------------
// lmr_pkg
// Shared constants, types and codes of the lagged Muskingum router.
// ----------------------------------------------------------------------------
package lmr_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int MAX_DELAY    = 64;

  localparam int CH_W   = 3;
  localparam int FLOW_W = 32;
  localparam int ST_W   = 48;
  localparam int COEF_W = 16;
  localparam int GAIN_W = 24;
  localparam int LEN_W  = 7;
  localparam int TS_W   = 38;

  localparam int PTR_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DEPTH  = NUM_CHANNELS * MAX_DELAY;
  localparam int ADDR_W = CH_W + PTR_W;

  localparam int IN_TDATA_W  = ((CH_W + FLOW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CH_W + FLOW_W + ST_W + 7) / 8) * 8;
  localparam int CFG_W       = GAIN_W;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_IN_NOW   = 3'd0,
    REG_COEF_IN_LAST  = 3'd1,
    REG_COEF_OUT_LAST = 3'd2,
    REG_STORAGE_GAIN  = 3'd3,
    REG_DELAY_LENGTH  = 3'd4
  } lmr_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MC0,
    ST_MC1,
    ST_MC2,
    ST_SUM1,
    ST_OUTF,
    ST_MO2,
    ST_SUM2,
    ST_INNER,
    ST_GLO,
    ST_GHI,
    ST_SUM3,
    ST_FIN
  } lmr_state_e;

  typedef struct packed {
    logic [COEF_W-1:0] coef_in_now;
    logic [COEF_W-1:0] coef_in_last;
    logic [COEF_W-1:0] coef_out_last;
    logic [GAIN_W-1:0] storage_gain;
    logic [LEN_W-1:0]  delay_length;
  } lmr_cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [FLOW_W-1:0] flow_in;
  } lmr_item_t;

  typedef struct packed {
    logic      valid;
    lmr_item_t item;
  } lmr_head_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } lmr_ctrl_t;

endpackage

@@ hw/rtl/lmr_front.sv @@
// ----------------------------------------------------------------------------
// lmr_front
// Accepts items, drops those of a channel that does not exist, and queues
// the rest for the compute back end.
// ----------------------------------------------------------------------------
module lmr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: channel [2:0], flow_in [34:3], zero pad
  input  logic [lmr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output lmr_pkg::lmr_head_t             head_o,
  input  lmr_pkg::lmr_ctrl_t             ctrl_i
);
  import lmr_pkg::*;

  localparam int QD    = 2;
  localparam int QP_W  = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  lmr_item_t        q_mem_q [QD];
  logic [QP_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  lmr_item_t        in_item;
  logic             accept, keep, push, pop;

  assign in_item.channel = s_axis_tdata[CH_W-1:0];
  assign in_item.flow_in = s_axis_tdata[CH_W+FLOW_W-1:CH_W];

  assign keep          = ({1'b0, in_item.channel} < (CH_W + 1)'(NUM_CHANNELS));
  assign s_axis_tready = (cnt_q != CNT_W'(QD)) && !ctrl_i.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && keep;
  assign pop           = ctrl_i.pop;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QP_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QP_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

@@ hw/rtl/lmr_back.sv @@
// ----------------------------------------------------------------------------
// lmr_back
// Delay line memory, per-channel state and a sequencer around one shared
// multiplier that forms the outflow and storage of each item.
// ----------------------------------------------------------------------------
module lmr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lmr_pkg::lmr_cfg_t               cfg_i,
  input  lmr_pkg::lmr_head_t              head_i,
  output lmr_pkg::lmr_ctrl_t              ctrl_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: channel_out [2:0], flow_out [34:3], storage [82:35], zero pad
  output logic [lmr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lmr_pkg::*;

  localparam int MA_W  = 35;
  localparam int MB_W  = COEF_W + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = 60;
  localparam int IN_W  = 34;
  localparam int GH_W  = GAIN_W / 2;
  localparam int PAD_W = OUT_TDATA_W - CH_W - FLOW_W - ST_W;

  localparam logic signed [ACC_W-1:0] HALF15 = ACC_W'(1) << 14;
  localparam logic signed [ACC_W-1:0] HALF16 = ACC_W'(1) << 15;
  localparam logic signed [ACC_W-1:0] O_MAX  = ACC_W'(32'h7fff_ffff);
  localparam logic signed [ACC_W-1:0] O_MIN  = ~O_MAX;
  localparam logic signed [TS_W+1:0]  T_MAX  = (TS_W + 2)'(38'h1f_ffff_ffff);
  localparam logic signed [TS_W+1:0]  T_MIN  = ~T_MAX;

  lmr_state_e state_q, state_d;
  logic       pop;

  // per-channel state
  logic [PTR_W-1:0]         wp_arr_q [NUM_CHANNELS];
  logic signed [FLOW_W-1:0] pd_arr_q [NUM_CHANNELS];
  logic signed [FLOW_W-1:0] po_arr_q [NUM_CHANNELS];
  logic signed [TS_W-1:0]   ts_arr_q [NUM_CHANNELS];

  // delay line memory
  logic [FLOW_W-1:0] mem [DEPTH];
  logic [FLOW_W-1:0] rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [FLOW_W-1:0] mem_wd;
  logic [ADDR_W-1:0] clr_q;

  // item datapath
  logic [CH_W-1:0]          ch_q;
  logic signed [FLOW_W-1:0] smp_q, dly_q, pd_q, po_q, of_q;
  logic signed [TS_W-1:0]   ts_q;
  logic                     same_q;
  logic signed [IN_W-1:0]   in_q;
  logic signed [P_W-1:0]    p_q, prod;
  logic signed [ACC_W-1:0]  acc_q, acc_r15, acc_r16;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [TS_W+1:0]   ts_sum;
  logic signed [TS_W-1:0]   ts_new;
  logic signed [FLOW_W-1:0] of_new;
  logic signed [ST_W-1:0]   st_val;

  // pointer arithmetic
  logic [LEN_W-1:0] len, wp_ext, rp_ext;
  logic [PTR_W-1:0] wp, rp;
  logic [CH_W-1:0]  hch;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_load;

  assign hch = head_i.item.channel;

  always_comb begin
    len = cfg_i.delay_length;
    if (len == '0) len = LEN_W'(1);
    if (len > LEN_W'(MAX_DELAY)) len = LEN_W'(MAX_DELAY);
    wp_ext = LEN_W'(wp_arr_q[hch]);
    if (wp_ext >= len) wp_ext = '0;
    rp_ext = wp_ext + LEN_W'(1);
    if (rp_ext == len) rp_ext = '0;
    wp = wp_ext[PTR_W-1:0];
    rp = rp_ext[PTR_W-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (head_i.valid) begin
          pop     = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_MC0;
      ST_MC0:   state_d = ST_MC1;
      ST_MC1:   state_d = ST_MC2;
      ST_MC2:   state_d = ST_SUM1;
      ST_SUM1:  state_d = ST_OUTF;
      ST_OUTF:  state_d = ST_MO2;
      ST_MO2:   state_d = ST_SUM2;
      ST_SUM2:  state_d = ST_INNER;
      ST_INNER: state_d = ST_GLO;
      ST_GLO:   state_d = ST_GHI;
      ST_GHI:   state_d = ST_SUM3;
      ST_SUM3:  state_d = ST_FIN;
      ST_FIN:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign ctrl_o.pop  = pop;
  assign ctrl_o.busy = (state_q == ST_CLEAR);
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // memory ports: clear sweep, or item write at the pointer and read of the next slot
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {hch, wp};
    mem_ra = {hch, rp};
    mem_wd = head_i.item.flow_in;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (pop) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (pop)    rdata_q <= mem[mem_ra];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MC0: begin
        mul_a = MA_W'(dly_q);
        mul_b = $signed({1'b0, cfg_i.coef_in_now});
      end
      ST_MC1: begin
        mul_a = MA_W'(pd_q);
        mul_b = $signed({1'b0, cfg_i.coef_in_last});
      end
      ST_MC2: begin
        mul_a = MA_W'(po_q);
        mul_b = $signed({1'b0, cfg_i.coef_out_last});
      end
      ST_OUTF: begin
        mul_a = MA_W'(dly_q);
        mul_b = $signed({1'b0, cfg_i.coef_in_last});
      end
      ST_MO2: begin
        mul_a = MA_W'(of_q);
        mul_b = $signed({1'b0, cfg_i.coef_out_last});
      end
      ST_GLO: begin
        mul_a = MA_W'(in_q);
        mul_b = $signed({(MB_W - GH_W)'(0), cfg_i.storage_gain[GH_W-1:0]});
      end
      ST_GHI: begin
        mul_a = MA_W'(in_q);
        mul_b = $signed({(MB_W - GH_W)'(0), cfg_i.storage_gain[GAIN_W-1:GH_W]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  assign acc_r15 = (acc_q + HALF15) >>> 15;
  assign acc_r16 = (acc_q + HALF16) >>> 16;

  always_comb begin
    if (acc_r15 > O_MAX)      of_new = O_MAX[FLOW_W-1:0];
    else if (acc_r15 < O_MIN) of_new = O_MIN[FLOW_W-1:0];
    else                      of_new = acc_r15[FLOW_W-1:0];
  end

  always_comb begin
    ts_sum = (TS_W + 2)'(ts_q) + (TS_W + 2)'(smp_q) - (TS_W + 2)'(dly_q);
    if (ts_sum > T_MAX)      ts_new = T_MAX[TS_W-1:0];
    else if (ts_sum < T_MIN) ts_new = T_MIN[TS_W-1:0];
    else                     ts_new = ts_sum[TS_W-1:0];
  end

  assign st_val = acc_r16[ST_W-1:0] + ST_W'(ts_q);

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          ch_q   <= hch;
          smp_q  <= head_i.item.flow_in;
          same_q <= (rp == wp);
          pd_q   <= pd_arr_q[hch];
          po_q   <= po_arr_q[hch];
          ts_q   <= ts_arr_q[hch];
        end
      end
      ST_READ:  dly_q <= same_q ? smp_q : $signed(rdata_q);
      ST_MC0:   ts_q <= ts_new;
      ST_MC1:   acc_q <= ACC_W'(p_q);
      ST_MC2:   acc_q <= acc_q + ACC_W'(p_q);
      ST_SUM1:  acc_q <= acc_q + ACC_W'(p_q);
      ST_OUTF:  of_q <= of_new;
      ST_MO2:   acc_q <= ACC_W'(p_q);
      ST_SUM2:  acc_q <= acc_q + ACC_W'(p_q);
      ST_INNER: in_q <= acc_r15[IN_W-1:0];
      ST_GHI:   acc_q <= ACC_W'(p_q);
      ST_SUM3:  acc_q <= acc_q + (ACC_W'(p_q) <<< GH_W);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wp_arr_q[i] <= '0;
        pd_arr_q[i] <= '0;
        po_arr_q[i] <= '0;
        ts_arr_q[i] <= '0;
      end
    end else begin
      if (pop) wp_arr_q[hch] <= rp;
      if (state_q == ST_MC0) begin
        ts_arr_q[ch_q] <= ts_new;
        pd_arr_q[ch_q] <= dly_q;
      end
      if (state_q == ST_MO2) po_arr_q[ch_q] <= of_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= {PAD_W'(0), st_val, of_q, ch_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hw/rtl/lagged_muskingum_router_top.sv @@
// ----------------------------------------------------------------------------
// lagged_muskingum_router_top
// Each item steps through READ, MC0, MC1, MC2, SUM1, OUTF, MO2, SUM2,
// INNER, GLO, GHI, SUM3 and FIN; the next item is popped after FIN.
// A two-entry queue takes items while the back end computes.
// Reset: coefficients to defaults, channel state to zero, then a sweep
// clears all 512 delay memory words; no item is accepted during the sweep.
// ----------------------------------------------------------------------------
module lagged_muskingum_router_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: channel [2:0], flow_in [34:3], zero pad
  input  logic [lmr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: channel_out [2:0], flow_out [34:3], storage [82:35], zero pad
  output logic [lmr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [lmr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lmr_pkg::CFG_W-1:0]       cfg_data_i
);
  import lmr_pkg::*;

  lmr_cfg_t  cfg_q;
  lmr_head_t head;
  lmr_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_in_now   <= COEF_W'(32768);
      cfg_q.coef_in_last  <= '0;
      cfg_q.coef_out_last <= '0;
      cfg_q.storage_gain  <= GAIN_W'(65536);
      cfg_q.delay_length  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (lmr_reg_e'(cfg_idx_i))
        REG_COEF_IN_NOW:   cfg_q.coef_in_now   <= cfg_data_i[COEF_W-1:0];
        REG_COEF_IN_LAST:  cfg_q.coef_in_last  <= cfg_data_i[COEF_W-1:0];
        REG_COEF_OUT_LAST: cfg_q.coef_out_last <= cfg_data_i[COEF_W-1:0];
        REG_STORAGE_GAIN:  cfg_q.storage_gain  <= cfg_data_i[GAIN_W-1:0];
        REG_DELAY_LENGTH:  cfg_q.delay_length  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  lmr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .head_o        (head),
    .ctrl_i        (ctrl)
  );

  lmr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .ctrl_o        (ctrl),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lagged Muskingum router. A burst driver streams
// channel/inflow items, a monitor checks each routed result field by field
// against an in-bench model of the delay lines, the Muskingum sum and the
// storage report. Register settings change between idle phases: extremes,
// lag lengths out of range, a lag change in use and transit overflow.
// ----------------------------------------------------------------------------
module tb;
  import lmr_pkg::*;

  localparam int MAX_CYCLES    = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 125;

  localparam longint FLOW_HI    = 64'sd2147483647;
  localparam longint FLOW_LO    = -FLOW_HI - 1;
  localparam longint TRANSIT_HI = (64'sd1 <<< (TS_W - 1)) - 1;
  localparam longint TRANSIT_LO = -TRANSIT_HI - 1;
  localparam longint STORE_HI   = (64'sd1 <<< (ST_W - 1)) - 1;
  localparam longint STORE_LO   = -STORE_HI - 1;

  typedef struct {
    logic [CH_W-1:0]   channel;
    logic [FLOW_W-1:0] flow;
    logic [ST_W-1:0]   storage;
  } routed_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  // register copies
  logic [COEF_W-1:0] w_now  = 16'd32768;
  logic [COEF_W-1:0] w_last = '0;
  logic [COEF_W-1:0] w_out  = '0;
  logic [GAIN_W-1:0] gain   = 24'd65536;
  logic [LEN_W-1:0]  lag_len = 7'd1;

  // per-channel routing state
  int          lag_line     [NUM_CHANNELS][MAX_DELAY];
  int unsigned lag_ptr      [NUM_CHANNELS];
  int          last_delayed [NUM_CHANNELS];
  int          last_outflow [NUM_CHANNELS];
  longint      in_transit   [NUM_CHANNELS];

  lmr_item_t pending_q[$];
  routed_t   expected_q[$];
  lmr_item_t offered;

  int burst_left  = 0;
  int gap_left    = 0;
  int taken       = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int rx_cycle    = 0;
  int cycles      = 0;
  int error_count = 0;

  lagged_muskingum_router_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint round_q(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic routed_t route_sample(lmr_item_t it);
    int unsigned len, wp, rp;
    int          ch;
    longint      sample, delayed, acc, outflow, inner, st;
    routed_t     r;
    ch  = int'(it.channel);
    len = 32'(lag_len);
    if (len < 1) len = 1;
    if (len > MAX_DELAY) len = MAX_DELAY;
    wp = lag_ptr[ch];
    if (wp >= len) wp = 0;
    sample = longint'(it.flow_in);
    lag_line[ch][wp] = int'(sample);
    rp = (wp + 1) % len;
    delayed = longint'(lag_line[ch][rp]);
    lag_ptr[ch] = rp;
    in_transit[ch] = clamp(in_transit[ch] + sample - delayed, TRANSIT_LO, TRANSIT_HI);
    acc = longint'(w_now) * delayed + longint'(w_last) * longint'(last_delayed[ch])
        + longint'(w_out) * longint'(last_outflow[ch]);
    outflow = clamp(round_q(acc, 15), FLOW_LO, FLOW_HI);
    inner = round_q(longint'(w_last) * delayed + longint'(w_out) * outflow, 15);
    st = clamp(round_q(inner * longint'(gain), 16) + in_transit[ch], STORE_LO, STORE_HI);
    last_delayed[ch] = int'(delayed);
    last_outflow[ch] = int'(outflow);
    r.channel = it.channel;
    r.flow    = outflow[FLOW_W-1:0];
    r.storage = st[ST_W-1:0];
    return r;
  endfunction

  function automatic void queue_item(int ch, logic [FLOW_W-1:0] f);
    lmr_item_t it;
    it.channel = CH_W'(ch);
    it.flow_in = f;
    pending_q.push_back(it);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      default: return COEF_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 24'd65536;
      2:       return 24'hFFFFFF;
      3:       return GAIN_W'($urandom());
      default: return GAIN_W'($urandom_range(65536, 262144));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'd127;
      3:       return LEN_W'($urandom_range(9, 64));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [FLOW_W-1:0] pick_flow();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2, 3:    return $urandom();
      4:       return 32'($urandom_range(0, 511)) - 32'd256;
      default: return 32'($urandom_range(0, 32'h00FFFFFF)) - 32'h00800000;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < 40)
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic drive_reg(lmr_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  // junk fills the unused upper data bits
  task automatic apply_config(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                              logic [COEF_W-1:0] c2, logic [GAIN_W-1:0] g,
                              logic [LEN_W-1:0] len, bit junk);
    logic [CFG_W-1:0] hi;
    hi = junk ? CFG_W'($urandom()) : '0;
    drive_reg(REG_COEF_IN_NOW,   {hi[CFG_W-1:COEF_W], c0});
    drive_reg(REG_COEF_IN_LAST,  {hi[CFG_W-1:COEF_W], c1});
    drive_reg(REG_COEF_OUT_LAST, {hi[CFG_W-1:COEF_W], c2});
    drive_reg(REG_STORAGE_GAIN,  g);
    drive_reg(REG_DELAY_LENGTH,  {hi[CFG_W-1:LEN_W], len});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    w_now   = c0;
    w_last  = c1;
    w_out   = c2;
    gain    = g;
    lag_len = len;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // item driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(route_sample(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          offered = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W - CH_W - FLOW_W){1'b0}},
                            offered.flow_in, offered.channel};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result-side backpressure, with one long hold
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) taken++;
    if (!hold_done && taken >= 400) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= rx_cycle[2];
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    routed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[CH_W-1:0] !== want.channel)
          report_mismatch("channel_out", 64'(m_axis_tdata[CH_W-1:0]), 64'(want.channel));
        if (m_axis_tdata[CH_W+FLOW_W-1:CH_W] !== want.flow)
          report_mismatch("flow_out", 64'(m_axis_tdata[CH_W+FLOW_W-1:CH_W]),
                          64'(want.flow));
        if (m_axis_tdata[CH_W+FLOW_W+ST_W-1:CH_W+FLOW_W] !== want.storage)
          report_mismatch("storage", 64'(m_axis_tdata[CH_W+FLOW_W+ST_W-1:CH_W+FLOW_W]),
                          64'(want.storage));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int fav;
    int ch;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes at reset settings
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      queue_item(c, 32'h7FFFFFFF);
      queue_item(c, 32'h80000000);
    end
    queue_item(0, 32'h0);
    queue_item(3, 32'hFFFFFFFF);
    queue_item(5, 32'h1);
    wait_idle();

    // all coefficients at field max, lag length zero
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 7'd0, 1'b1);
    queue_item(1, 32'h7FFFFFFF);
    queue_item(1, 32'h7FFFFFFF);
    queue_item(1, 32'h80000000);
    queue_item(1, 32'h80000000);
    queue_item(1, 32'h0);
    queue_item(2, 32'h80000000);
    queue_item(2, 32'h7FFFFFFF);
    queue_item(2, 32'h00010000);
    wait_idle();

    // lag over range, then a lag change in use that runs transit into its limits
    apply_config(16'd32768, 16'd16384, 16'd16384, 24'd131072, 7'd127, 1'b0);
    for (int n = 0; n < MAX_DELAY + 5; n++) begin
      queue_item(7, (n == 5) ? 32'h80000000 : 32'h7FFFFFFF);
      queue_item(6, (n == 5) ? 32'h7FFFFFFF : 32'h80000000);
    end
    wait_idle();
    apply_config(16'd32768, 16'd16384, 16'd16384, 24'd131072, 7'd2, 1'b0);
    queue_item(7, 32'h7FFFFFFF);
    queue_item(6, 32'h80000000);
    wait_idle();
    apply_config(16'd32768, 16'd16384, 16'd16384, 24'd131072, 7'd64, 1'b0);
    for (int n = 0; n < 6; n++) begin
      queue_item(7, 32'h7FFFFFFF);
      queue_item(6, 32'h80000000);
    end
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      apply_config(pick_coef(), pick_coef(), pick_coef(), pick_gain(), pick_len(), p[0]);
      fav = $urandom_range(0, NUM_CHANNELS - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = ($urandom_range(0, 1) == 0) ? fav : $urandom_range(0, NUM_CHANNELS - 1);
        queue_item(ch, pick_flow());
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
